// ===== rtl/pmul_pkg.sv =====
// ----------------------------------------------------------------------------
// pmul_pkg
// Shared widths, codes and the control bundle that the top level broadcasts
// to every cell of the polynomial multiplier chain.
// ----------------------------------------------------------------------------
package pmul_pkg;

   localparam int COEF_W  = 16;   // coefficient field on the request channel
   localparam int POWER_W = 6;    // power field on the response channel
   localparam int TERM_W  = 37;   // product term field on the response channel
   localparam int CNT_W   = 6;    // coefficient counts and step counter

   localparam int MAX_TERMS_DEF = 32;
   localparam int COEF_BITS_DEF = 16;

   localparam logic OP_FIRST  = 1'b0;
   localparam logic OP_SECOND = 1'b1;

   typedef struct packed {
      logic             a_we;
      logic             b_we;
      logic [CNT_W-1:0] a_idx;
      logic [CNT_W-1:0] b_idx;
      logic [CNT_W-1:0] a_len;
      logic             step;
      logic             clear;
   } pmul_cell_ctrl_type;

endpackage

// ===== rtl/pmul_req_if.sv =====
// ----------------------------------------------------------------------------
// pmul_req_if
// Request channel: one coefficient of either polynomial per beat.
// ----------------------------------------------------------------------------
interface pmul_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic signed [pmul_pkg::COEF_W-1:0]  coefficient;
   logic                                final_term;

   modport source (output valid, output operation, output coefficient,
                   output final_term, input ready);
   modport sink   (input valid, input operation, input coefficient,
                   input final_term, output ready);
endinterface

// ===== rtl/pmul_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pmul_rsp_if
// Response channel: one product coefficient per beat.
// ----------------------------------------------------------------------------
interface pmul_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [pmul_pkg::POWER_W-1:0] power;
   logic signed [pmul_pkg::TERM_W-1:0]  product_term;
   logic                                last_term;

   modport source (output valid, output power, output product_term,
                   output last_term, input ready);
   modport sink   (input valid, input power, input product_term,
                   input last_term, output ready);
endinterface

// ===== rtl/pmul_cell.sv =====
// ----------------------------------------------------------------------------
// pmul_cell
// One tap of the transposed convolution chain. Holds one coefficient of
// each polynomial and one partial sum; on each step it adds its product to
// the partial sum handed down from its upper neighbor and passes its second
// polynomial coefficient one place toward the chain head.
// ----------------------------------------------------------------------------
module pmul_cell #(
   parameter int COEF_BITS = pmul_pkg::COEF_BITS_DEF,
   parameter int INDEX     = 0
) (
   input  logic                                clock,
   input  pmul_pkg::pmul_cell_ctrl_type        ctrl,
   input  logic signed [COEF_BITS-1:0]         wr_coef,
   input  logic signed [COEF_BITS-1:0]         x,
   input  logic signed [COEF_BITS-1:0]         b_next,
   input  logic signed [pmul_pkg::TERM_W-1:0]  acc_next,
   output logic signed [COEF_BITS-1:0]         b_out,
   output logic signed [pmul_pkg::TERM_W-1:0]  acc_out
);

   localparam int PROD_W = 2 * COEF_BITS;
   localparam logic [pmul_pkg::CNT_W-1:0] MY_IDX = pmul_pkg::CNT_W'(INDEX);

   logic signed [COEF_BITS-1:0]        a_ff;
   logic signed [COEF_BITS-1:0]        b_ff;
   logic signed [pmul_pkg::TERM_W-1:0] acc_ff;
   logic signed [pmul_pkg::TERM_W-1:0] acc_in;
   logic signed [PROD_W-1:0]           prod;
   logic signed [pmul_pkg::TERM_W-1:0] prod_ext;
   logic                               a_on;

   // taps above the first polynomial's length contribute nothing
   assign a_on = (MY_IDX < ctrl.a_len);
   assign prod = a_on ? (a_ff * x) : PROD_W'(0);

   generate
      if (PROD_W >= pmul_pkg::TERM_W) begin : g_trunc
         assign prod_ext = prod[pmul_pkg::TERM_W-1:0];
      end else begin : g_sext
         assign prod_ext = {{(pmul_pkg::TERM_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
   endgenerate

   assign acc_in = acc_next + prod_ext;

   always_ff @(posedge clock) begin
      if (ctrl.a_we && (ctrl.a_idx == MY_IDX)) begin
         a_ff <= wr_coef;
      end
      if (ctrl.b_we && (ctrl.b_idx == MY_IDX)) begin
         b_ff <= wr_coef;
      end else if (ctrl.step) begin
         b_ff <= b_next;
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.step) begin
         acc_ff <= acc_in;
      end
   end

   assign b_out   = b_ff;
   assign acc_out = acc_ff;

endmodule

// ===== rtl/polynomial_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiplier_core
// Linear convolution of two streamed polynomials on a chain of cells.
//
//   channel  dir  beat contents                           accepted when
//   req      in   operation, coefficient, final_term      valid && ready
//   rsp      out  power, product_term, last_term          valid && ready
//
// After the marked last coefficient of the second polynomial, the chain
// steps once per product coefficient, producing a run of lenA+lenB-1 beats;
// each rsp stall freezes the chain. If the first polynomial is not empty,
// req is held off from the marked beat until the last product beat is taken.
// Reset clears counts and flags only.
// ----------------------------------------------------------------------------
module polynomial_multiplier_core #(
   parameter int MAX_TERMS = pmul_pkg::MAX_TERMS_DEF,
   parameter int COEF_BITS = pmul_pkg::COEF_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pmul_req_if.sink     req,
   pmul_rsp_if.source   rsp
);

   localparam int CW = pmul_pkg::CNT_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

   logic [CW-1:0] first_count_ff,  first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic          first_complete_ff, first_complete_in;
   logic          feeding_ff, feeding_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] step_cnt_ff, step_cnt_in;
   logic [CW-1:0] run_last_ff, run_last_in;
   logic [CW-1:0] b_len_ff, b_len_in;
   logic [pmul_pkg::POWER_W-1:0] power_ff, power_in;
   logic          last_ff, last_in;

   logic          accept;
   logic          is_first;
   logic          is_second;
   logic [CW-1:0] a_wr_idx;
   logic          a_we;
   logic          b_we;
   logic [CW-1:0] b_cnt_new;
   logic          start;
   logic          step;

   logic signed [COEF_BITS-1:0] wr_coef;
   logic signed [COEF_BITS-1:0] x;
   logic signed [COEF_BITS-1:0]        b_link   [0:MAX_TERMS];
   logic signed [pmul_pkg::TERM_W-1:0] acc_link [0:MAX_TERMS];

   pmul_pkg::pmul_cell_ctrl_type ctrl;

   assign req.ready = !feeding_ff && !pend_ff;
   assign accept    = req.valid && req.ready;
   assign is_first  = accept && (req.operation == pmul_pkg::OP_FIRST);
   assign is_second = accept && (req.operation == pmul_pkg::OP_SECOND);

   // narrow or widen the field to the stored coefficient width
   generate
      if (COEF_BITS <= pmul_pkg::COEF_W) begin : g_narrow
         assign wr_coef = req.coefficient[COEF_BITS-1:0];
      end else begin : g_wide
         assign wr_coef = {{(COEF_BITS-pmul_pkg::COEF_W){1'b0}}, req.coefficient};
      end
   endgenerate

   // a first-polynomial beat after a completed one restarts the store
   assign a_wr_idx  = first_complete_ff ? '0 : first_count_ff;
   assign a_we      = is_first && (a_wr_idx < MAX_CNT);
   assign b_we      = is_second && (second_count_ff < MAX_CNT);
   assign b_cnt_new = second_count_ff + CW'(b_we);
   assign start     = is_second && req.final_term && (first_count_ff != '0);
   assign step      = feeding_ff && (!pend_ff || rsp.ready);

   assign ctrl.a_we  = a_we;
   assign ctrl.b_we  = b_we;
   assign ctrl.a_idx = a_wr_idx;
   assign ctrl.b_idx = second_count_ff;
   assign ctrl.a_len = first_count_ff;
   assign ctrl.step  = step;
   assign ctrl.clear = start;

   // feed zeros once the second polynomial is used up
   assign x = (step_cnt_ff < b_len_ff) ? b_link[0] : '0;

   assign b_link[MAX_TERMS]   = '0;
   assign acc_link[MAX_TERMS] = '0;

   generate
      for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
         pmul_cell #(
            .COEF_BITS (COEF_BITS),
            .INDEX     (i)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .wr_coef  (wr_coef),
            .x        (x),
            .b_next   (b_link[i+1]),
            .acc_next (acc_link[i+1]),
            .b_out    (b_link[i]),
            .acc_out  (acc_link[i])
         );
      end
   endgenerate

   always_comb begin
      first_count_in    = first_count_ff;
      second_count_in   = second_count_ff;
      first_complete_in = first_complete_ff;
      feeding_in        = feeding_ff;
      pend_in           = pend_ff;
      step_cnt_in       = step_cnt_ff;
      run_last_in       = run_last_ff;
      b_len_in          = b_len_ff;
      power_in          = power_ff;
      last_in           = last_ff;

      if (is_first) begin
         first_count_in = a_wr_idx + CW'(a_we);
         if (first_complete_ff) begin
            second_count_in = '0;
         end
         first_complete_in = req.final_term ? 1'b1 : (first_complete_ff ? 1'b0 : 1'b0);
      end
      if (is_second) begin
         second_count_in = req.final_term ? '0 : b_cnt_new;
      end
      if (start) begin
         feeding_in  = 1'b1;
         step_cnt_in = '0;
         b_len_in    = b_cnt_new;
         run_last_in = first_count_ff + b_cnt_new - CW'(2);
      end

      // drop the held beat when taken; a step refills it
      if (pend_ff && rsp.ready) begin
         pend_in = 1'b0;
      end
      if (step) begin
         pend_in     = 1'b1;
         power_in    = pmul_pkg::POWER_W'(step_cnt_ff);
         last_in     = (step_cnt_ff == run_last_ff);
         step_cnt_in = step_cnt_ff + CW'(1);
         if (step_cnt_ff == run_last_ff) begin
            feeding_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff    <= '0;
         second_count_ff   <= '0;
         first_complete_ff <= 1'b0;
         feeding_ff        <= 1'b0;
         pend_ff           <= 1'b0;
      end else begin
         first_count_ff    <= first_count_in;
         second_count_ff   <= second_count_in;
         first_complete_ff <= first_complete_in;
         feeding_ff        <= feeding_in;
         pend_ff           <= pend_in;
      end
      step_cnt_ff <= step_cnt_in;
      run_last_ff <= run_last_in;
      b_len_ff    <= b_len_in;
      power_ff    <= power_in;
      last_ff     <= last_in;
   end

   // the head cell's partial sum is the finished product coefficient
   assign rsp.valid        = pend_ff;
   assign rsp.power        = power_ff;
   assign rsp.product_term = acc_link[0];
   assign rsp.last_term    = last_ff;

endmodule

// ===== sim/polynomial_multiplier_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_multiplier_core_test
// Streams coefficients of two polynomials into the core and compares every
// product beat, in order, against a bench convolution or a table value. A
// short table covers the reset state, extreme values and the reuse and
// early-mark rules. Random polynomials follow, among them one run that
// overflows both stores, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module polynomial_multiplier_core_test;

   localparam int MAX_TERMS       = pmul_pkg::MAX_TERMS_DEF;
   localparam int NUM_ROWS        = 23;
   localparam int RANDOM_BEATS    = 90;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 400000;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_SINGLE} check_kind_type;
   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_EVERY_FOURTH, RX_BURSTY} rx_mode_type;
   typedef enum logic [1:0] {SEQ_CLEAN, SEQ_EARLY_B, SEQ_NOISE} seq_kind_type;

   typedef struct packed {
      logic                               operation;
      logic signed [pmul_pkg::COEF_W-1:0] coefficient;
      logic                               final_term;
      check_kind_type                     check;
      logic signed [pmul_pkg::TERM_W-1:0] product_term;
   } stim_row_type;

   typedef struct packed {
      logic        [pmul_pkg::POWER_W-1:0] power;
      logic signed [pmul_pkg::TERM_W-1:0]  product_term;
      logic                                last_term;
   } product_type;

   logic clock;
   logic reset;

   pmul_req_if req_bus ();
   pmul_rsp_if rsp_bus ();

   polynomial_multiplier_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // bench copy of the coefficient stores
   logic signed [pmul_pkg::COEF_W-1:0] poly_a [MAX_TERMS];
   logic signed [pmul_pkg::COEF_W-1:0] poly_b [MAX_TERMS];
   int                                 a_count;
   int                                 b_count;
   bit                                 a_sealed;

   product_type run_terms [$];
   product_type pending_products [$];

   int  error_count;
   int  beats_sent;
   int  products_checked;
   int  runs_checked;
   int  longest_run;
   int  burst_left;
   int  cycle_count;
   bit  hold_off_pending;

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{pmul_pkg::OP_SECOND, 16'sd1,     1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sd5,     1'b1, CHECK_NONE,   37'sd0},   // A still empty
      '{pmul_pkg::OP_FIRST,  16'sh8000,  1'b1, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sh8000,  1'b1, CHECK_SINGLE, 37'sd1073741824},
      '{pmul_pkg::OP_SECOND, 16'sd32767, 1'b1, CHECK_SINGLE, -37'sd1073709056}, // A reused
      '{pmul_pkg::OP_FIRST,  16'sd32767, 1'b1, CHECK_MODEL,  37'sd0},   // new A
      '{pmul_pkg::OP_SECOND, 16'sd32767, 1'b1, CHECK_SINGLE, 37'sd1073676289},
      '{pmul_pkg::OP_SECOND, -16'sd1,    1'b1, CHECK_SINGLE, -37'sd32767},
      '{pmul_pkg::OP_FIRST,  16'sd0,     1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_FIRST,  16'sd1,     1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_FIRST,  -16'sd1,    1'b1, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sd3,     1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, -16'sd2,    1'b1, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_FIRST,  16'sd7,     1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sd2,     1'b1, CHECK_MODEL,  37'sd0},   // A still open
      '{pmul_pkg::OP_FIRST,  16'sd9,     1'b0, CHECK_MODEL,  37'sd0},   // appends to A
      '{pmul_pkg::OP_FIRST,  16'sh8000,  1'b1, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sd32767, 1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sh8000,  1'b1, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_FIRST,  16'sh8000,  1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_FIRST,  16'sh8000,  1'b1, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sh8000,  1'b0, CHECK_MODEL,  37'sd0},
      '{pmul_pkg::OP_SECOND, 16'sh8000,  1'b1, CHECK_MODEL,  37'sd0}    // sum past 32 bits
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("polynomial_multiplier_core test failed");
      $finish;
   end

   // Update the bench stores with one beat and leave any products in run_terms.
   function automatic void convolve_beat(logic op,
                                         logic signed [pmul_pkg::COEF_W-1:0] coef,
                                         logic fin);
      longint acc;
      int     n;
      int     k;
      int     i;
      run_terms.delete();
      if (op == pmul_pkg::OP_FIRST) begin
         if (a_sealed) begin
            a_count  = 0;
            b_count  = 0;
            a_sealed = 1'b0;
         end
         if (a_count < MAX_TERMS) begin
            poly_a[a_count] = coef;
            a_count++;
         end
         if (fin) a_sealed = 1'b1;
      end else begin
         if (b_count < MAX_TERMS) begin
            poly_b[b_count] = coef;
            b_count++;
         end
         if (fin) begin
            if (a_count != 0 && b_count != 0) begin
               n = a_count + b_count - 1;
               for (k = 0; k < n; k++) begin
                  acc = 0;
                  for (i = 0; i < a_count; i++) begin
                     if (i <= k && k - i < b_count)
                        acc += longint'(poly_a[i]) * longint'(poly_b[k - i]);
                  end
                  run_terms.push_back('{power: pmul_pkg::POWER_W'(k),
                                        product_term: acc[pmul_pkg::TERM_W-1:0],
                                        last_term: (k == n - 1)});
               end
               if (n > longest_run) longest_run = n;
            end
            b_count = 0;
         end
      end
   endfunction

   function automatic logic signed [pmul_pkg::COEF_W-1:0] random_coef();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd0;
         default: return pmul_pkg::COEF_W'($urandom);
      endcase
   endfunction

   function automatic int random_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(7, 20);
      return $urandom_range(1, 5);
   endfunction

   // Offer one beat, wait for it to be taken, then queue what it must produce.
   task automatic send_coefficient(input stim_row_type row);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= row.operation;
      req_bus.coefficient <= row.coefficient;
      req_bus.final_term  <= row.final_term;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      convolve_beat(row.operation, row.coefficient, row.final_term);
      case (row.check)
         CHECK_MODEL:  foreach (run_terms[j]) pending_products.push_back(run_terms[j]);
         CHECK_SINGLE: pending_products.push_back('{power: '0,
                                                    product_term: row.product_term,
                                                    last_term: 1'b1});
         default: ;
      endcase
   endtask

   task automatic send_poly(input logic op, input int len, input bit close);
      stim_row_type row;
      for (int j = 0; j < len; j++) begin
         row = '{op, random_coef(), close && (j == len - 1), CHECK_MODEL, '0};
         send_coefficient(row);
      end
   endtask

   // receiver: changes stall pattern every stretch, holds off on request
   initial begin
      rx_mode_type mode;
      int          phase_left;
      int          stall_left;
      int          tick;
      mode       = RX_STREAM;
      phase_left = 0;
      stall_left = 0;
      tick       = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (phase_left == 0) begin
               mode       = rx_mode_type'($urandom_range(0, 3));
               phase_left = $urandom_range(40, 160);
            end
            phase_left--;
            tick++;
            case (mode)
               RX_STREAM:       rsp_bus.ready <= 1'b1;
               RX_COIN:         rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_EVERY_FOURTH: rsp_bus.ready <= (tick % 4 == 0);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_bus.ready <= 1'b0;
                  end else if ($urandom_range(0, 7) == 0) begin
                     stall_left = $urandom_range(1, 10);
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     rsp_bus.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      product_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_products.size() == 0) begin
            $error("unexpected product beat: power %0d product_term %0d last_term %0b",
                   rsp_bus.power, rsp_bus.product_term, rsp_bus.last_term);
            error_count++;
         end else begin
            want = pending_products.pop_front();
            products_checked++;
            if (rsp_bus.last_term) runs_checked++;
            if (rsp_bus.power !== want.power) begin
               $error("power: expected %0d, got %0d", want.power, rsp_bus.power);
               error_count++;
            end
            if (rsp_bus.product_term !== want.product_term) begin
               $error("product_term: expected %0d, got %0d",
                      $signed(want.product_term), rsp_bus.product_term);
               error_count++;
            end
            if (rsp_bus.last_term !== want.last_term) begin
               $error("last_term: expected %0b, got %0b", want.last_term, rsp_bus.last_term);
               error_count++;
            end
         end
      end
   end

   initial begin
      int           random_end;
      seq_kind_type kind;
      int           pick;
      stim_row_type row;
      cycle_count         = 0;
      error_count         = 0;
      beats_sent          = 0;
      products_checked    = 0;
      runs_checked        = 0;
      longest_run         = 0;
      burst_left          = 0;
      hold_off_pending    = 1'b0;
      a_count             = 0;
      b_count             = 0;
      a_sealed            = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.operation   = pmul_pkg::OP_FIRST;
      req_bus.coefficient = '0;
      req_bus.final_term  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) send_coefficient(directed_rows[r]);

      // overflow both stores, the marks landing on dropped beats
      random_end = beats_sent + RANDOM_BEATS;
      send_poly(pmul_pkg::OP_FIRST, MAX_TERMS + 2, 1'b1);
      send_poly(pmul_pkg::OP_SECOND, MAX_TERMS + 3, 1'b1);
      hold_off_pending = 1'b1;

      while (beats_sent < random_end) begin
         pick = $urandom_range(0, 9);
         kind = (pick < 7) ? SEQ_CLEAN : (pick < 9) ? SEQ_EARLY_B : SEQ_NOISE;
         case (kind)
            SEQ_CLEAN: begin
               send_poly(pmul_pkg::OP_FIRST, random_length(), 1'b1);
               repeat ($urandom_range(1, 3))
                  send_poly(pmul_pkg::OP_SECOND, random_length(), 1'b1);
            end
            SEQ_EARLY_B: begin
               send_poly(pmul_pkg::OP_FIRST, $urandom_range(1, 3), 1'b0);
               send_poly(pmul_pkg::OP_SECOND, $urandom_range(1, 3), 1'b1);
               send_poly(pmul_pkg::OP_FIRST, $urandom_range(1, 2), 1'b1);
               send_poly(pmul_pkg::OP_SECOND, $urandom_range(1, 3), 1'b1);
            end
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  row = '{1'($urandom_range(0, 1)), random_coef(),
                          ($urandom_range(0, 2) == 0), CHECK_MODEL, '0};
                  send_coefficient(row);
               end
            end
         endcase
      end

      req_bus.valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d coefficient beats; checked %0d product terms over %0d runs.",
               beats_sent, products_checked, runs_checked);
      $display("Longest product had %0d terms; store overflow and a %0d-cycle hold-off ran.",
               longest_run, HOLD_OFF_CYCLES);
      if (error_count == 0) begin
         $display("polynomial_multiplier_core test passed");
      end else begin
         $display("polynomial_multiplier_core test failed");
      end
      $finish;
   end

endmodule
